@@ src/ascon_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ascon-Hash256 engine package
// Shared types, constants and the Ascon round function.
// ----------------------------------------------------------------------------
package ascon_pkg;

  localparam logic [63:0] HASH_IV      = 64'h0000_0801_00CC_0002;
  localparam logic [63:0] PAD_WORD     = 64'h0000_0000_0000_0001;
  localparam int          NUM_ROUNDS   = 12;
  localparam logic [3:0]  LAST_ROUND   = 4'(NUM_ROUNDS - 1);
  localparam logic [1:0]  LAST_WORD    = 2'd3;
  localparam int          CMD_DEPTH_D  = 2;
  localparam int          OUT_DEPTH_D  = 4;

  typedef logic [4:0][63:0] sponge_t;

  typedef struct packed {
    logic [63:0] message_block;
    logic [3:0]  byte_count;
    logic        final_item;
  } item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } result_t;

  typedef struct packed {
    logic [63:0] word;
    logic        fin;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ROUNDS,
    PH_EMIT
  } back_phase_t;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int r);
    rotr = (v >> r) | (v << (64 - r));
  endfunction

  function automatic sponge_t ascon_round(input sponge_t s, input logic [3:0] r);
    logic [63:0] a0, a1, a2, a3, a4;
    logic [63:0] t0, t1, t2, t3, t4;
    sponge_t     o;
    a0 = s[0];
    a1 = s[1];
    a2 = s[2] ^ {56'd0, ~r, r};
    a3 = s[3];
    a4 = s[4];
    a0 = a0 ^ a4;
    a4 = a4 ^ a3;
    a2 = a2 ^ a1;
    t0 = ~a0 & a1;
    t1 = ~a1 & a2;
    t2 = ~a2 & a3;
    t3 = ~a3 & a4;
    t4 = ~a4 & a0;
    a0 = a0 ^ t1;
    a1 = a1 ^ t2;
    a2 = a2 ^ t3;
    a3 = a3 ^ t4;
    a4 = a4 ^ t0;
    a1 = a1 ^ a0;
    a0 = a0 ^ a4;
    a3 = a3 ^ a2;
    a2 = ~a2;
    o[0] = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
    o[1] = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
    o[2] = a2 ^ rotr(a2, 1) ^ rotr(a2, 6);
    o[3] = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
    o[4] = a4 ^ rotr(a4, 7) ^ rotr(a4, 41);
    return o;
  endfunction

  function automatic sponge_t ascon_init_state();
    sponge_t s;
    s    = '0;
    s[0] = HASH_IV;
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      s = ascon_round(s, 4'(i));
    end
    return s;
  endfunction

  localparam sponge_t INIT_STATE = ascon_init_state();

endpackage

@@ src/ascon_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ascon small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module ascon_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  T     wdata,
  output logic full,
  input  logic rd,
  output T     rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr & ~full;
  assign do_rd  = rd & ~empty;
  assign rdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/ascon_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ascon input front end
// Accepts message items, applies padding and splits them into commands.
// ----------------------------------------------------------------------------
module ascon_front
  import ascon_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item,
  output logic  full,
  output logic  cmd_push,
  output cmd_t  cmd,
  input  logic  cmd_full
);

  logic        pad_pending;
  logic [63:0] tail_word;
  logic        accept;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < item.byte_count) begin
        tail_word[8*i +: 8] = item.message_block[8*i +: 8];
      end else if (4'(i) == item.byte_count) begin
        tail_word[8*i +: 8] = 8'h01;
      end else begin
        tail_word[8*i +: 8] = 8'h00;
      end
    end
  end

  assign full   = pad_pending | cmd_full;
  assign accept = push & ~full;

  always_comb begin
    cmd_push = 1'b0;
    cmd      = '{word: item.message_block, fin: 1'b0};
    if (pad_pending) begin
      cmd_push = 1'b1;
      cmd      = '{word: PAD_WORD, fin: 1'b1};
    end else if (accept) begin
      cmd_push = 1'b1;
      if (item.final_item && !item.byte_count[3]) begin
        cmd = '{word: tail_word, fin: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_pending <= 1'b0;
    end else if (pad_pending) begin
      if (!cmd_full) begin
        pad_pending <= 1'b0;
      end
    end else if (accept && item.final_item && item.byte_count[3]) begin
      pad_pending <= 1'b1;
    end
  end

endmodule

@@ src/ascon_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ascon permutation back end
// Holds the sponge, runs one round per cycle and squeezes the digest.
// ----------------------------------------------------------------------------
module ascon_back
  import ascon_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  logic    cmd_empty,
  output logic    cmd_pop,
  output result_t res,
  output logic    res_push,
  input  logic    res_full
);

  sponge_t     st;
  sponge_t     st_next;
  sponge_t     round_out;
  back_phase_t phase;
  back_phase_t phase_next;
  logic [3:0]  rnd;
  logic [3:0]  rnd_next;
  logic        fin;
  logic        fin_next;
  logic [1:0]  widx;
  logic [1:0]  widx_next;

  assign round_out = ascon_round(st, rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= INIT_STATE;
      phase <= PH_IDLE;
      rnd   <= '0;
      fin   <= 1'b0;
      widx  <= '0;
    end else begin
      st    <= st_next;
      phase <= phase_next;
      rnd   <= rnd_next;
      fin   <= fin_next;
      widx  <= widx_next;
    end
  end

  always_comb begin
    st_next    = st;
    phase_next = phase;
    rnd_next   = rnd;
    fin_next   = fin;
    widx_next  = widx;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = '{digest_word: st[0], word_index: widx, last_word: (widx == LAST_WORD)};
    case (phase)
      PH_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          st_next[0] = st[0] ^ cmd.word;
          fin_next   = cmd.fin;
          rnd_next   = '0;
          widx_next  = '0;
          phase_next = PH_ROUNDS;
        end
      end
      PH_ROUNDS: begin
        st_next = round_out;
        if (rnd == LAST_ROUND) begin
          rnd_next = '0;
          if (fin) begin
            phase_next = PH_EMIT;
          end else if (!cmd_empty) begin
            // chain the next block straight into the round loop
            cmd_pop    = 1'b1;
            st_next[0] = round_out[0] ^ cmd.word;
            fin_next   = cmd.fin;
            widx_next  = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end else begin
          rnd_next = rnd + 1'b1;
        end
      end
      PH_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (widx == LAST_WORD) begin
            st_next    = INIT_STATE;
            fin_next   = 1'b0;
            widx_next  = '0;
            phase_next = PH_IDLE;
          end else begin
            widx_next  = widx + 1'b1;
            rnd_next   = '0;
            phase_next = PH_ROUNDS;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

endmodule

@@ src/ascon_hash256_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ascon-Hash256 engine
// Message items enter through a queue-style push/full port; digest words
// leave through a queue-style empty/pop port.
//
// Each item carries up to eight message bytes (first byte in bits 7:0), a
// byte count and a final flag. Non-final items absorb a full eight-byte
// block. The final item pads, and four digest words (index 0..3, last_word
// on index 3) come out in order.
// Each block runs all NUM_ROUNDS Ascon rounds, one round per cycle in the back end;
// blocks chain with no gap while the command queue holds work. Each digest
// word after the first follows another full permutation. A final item that
// carries eight bytes also absorbs an extra pad block.
// Reset empties both queues and loads the precomputed initial sponge.
// When the receiver stalls, up to four digest words wait in the output
// queue; after that the back end holds, and full rises once the command
// queue fills.
// ----------------------------------------------------------------------------
module ascon_hash256_engine_top
  import ascon_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_D,
  parameter int OUT_DEPTH = OUT_DEPTH_D
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   item,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic    cmd_push;
  cmd_t    cmd_wdata;
  logic    cmd_full;
  cmd_t    cmd_rdata;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t res_wdata;
  logic    res_push;
  logic    res_full;

  ascon_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_wdata),
    .cmd_full (cmd_full)
  );

  ascon_fifo #(
    .DEPTH (CMD_DEPTH),
    .T     (cmd_t)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .rd    (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  ascon_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_rdata),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res_wdata),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  ascon_fifo #(
    .DEPTH (OUT_DEPTH),
    .T     (result_t)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
